FILE: hw/rtl/cmuc_pkg.sv
// ----------------------------------------------------------------------------
// cmuc_pkg
// Shared constants and types for the complex matrix unitarity checker.
// ----------------------------------------------------------------------------
package cmuc_pkg;

  localparam int MAT_DIM    = 3;
  localparam int DEPTH      = MAT_DIM * MAT_DIM;
  localparam int IDX_W      = $clog2(MAT_DIM);
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int K_W        = $clog2(MAT_DIM + 2);
  localparam int ACC_W      = 33 + $clog2(MAT_DIM);
  localparam int ROOT_W     = 64;
  localparam int ROOT_ITERS = 32;
  localparam int ITER_W     = $clog2(ROOT_ITERS);
  localparam int TOL_RESET  = 2;
  localparam int ONE_Q14    = 16384;
  localparam int HALF_Q14   = 8192;
  localparam int SAT16      = 65535;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ACC  = 8'b0000_0010,
    ST_PREP = 8'b0000_0100,
    ST_SQR  = 8'b0000_1000,
    ST_LOAD = 8'b0001_0000,
    ST_ROOT = 8'b0010_0000,
    ST_FIN  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } ctrl_state_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_last;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_a;
    logic [ADDR_W-1:0] rd_b;
    logic              acc_clr;
    logic              abs_en;
    logic              sq_en;
    logic              root_ld_diag;
    logic              root_ld_off;
    logic              root_step;
    logic              fin_en;
    logic              diag;
    logic              clr_best;
    logic              out_en;
  } dp_cmd_t;

endpackage

FILE: hw/rtl/complex_matrix_unitarity_check.sv
// ----------------------------------------------------------------------------
// complex_matrix_unitarity_check
// Max norm / orthogonality deviation of a complex square matrix, Q2.14.
// ----------------------------------------------------------------------------
// channel  | ports                                    | handshake
// input    | in_elem_real, in_elem_imag, in_last_elem | start & !busy
// result   | out_peak_dev, out_exceeds                | out_valid, one cycle
// config   | cfg_tolerance                            | cfg_valid & cfg_ready
//
// Elements are stored in one cycle each while idle. The element marked last
// starts the evaluation: for each of the MAT_DIM*(MAT_DIM+1)/2 row pairs, a
// MAC pass, up to 3 setup steps, the bitwise root passes and a finish step;
// then the result step. The result strobe comes in the first idle cycle.
// Synchronous active-low reset; cfg_ready is always high. The receiver
// cannot stall.
// ----------------------------------------------------------------------------
module complex_matrix_unitarity_check import cmuc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_elem_real,
  input  logic signed [15:0] in_elem_imag,
  input  logic               in_last_elem,
  output logic               out_valid,
  output logic [15:0]        out_peak_dev,
  output logic               out_exceeds,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_tolerance
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  cmuc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last_elem (in_last_elem),
    .busy         (busy),
    .cmd          (cmd)
  );

  cmuc_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_elem_real  (in_elem_real),
    .in_elem_imag  (in_elem_imag),
    .cfg_valid     (cfg_valid),
    .cfg_tolerance (cfg_tolerance),
    .out_valid     (out_valid),
    .out_peak_dev  (out_peak_dev),
    .out_exceeds   (out_exceeds)
  );

endmodule

FILE: hw/rtl/cmuc_ctrl.sv
// ----------------------------------------------------------------------------
// cmuc_ctrl
// Sequencer: walks row pairs, drives the MAC, root and result steps.
// ----------------------------------------------------------------------------
module cmuc_ctrl import cmuc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_last_elem,
  output logic    busy,
  output dp_cmd_t cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAT_DIM - 1);

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    it_nxt    = it_r;
    cmd       = '0;
    cmd.rd_a  = ADDR_W'(int'(j_r) * MAT_DIM + int'(k_r));
    cmd.rd_b  = ADDR_W'(int'(i_r) * MAT_DIM + int'(k_r));
    cmd.diag  = (i_r == j_r);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_last = in_last_elem;
          if (in_last_elem) begin
            cmd.clr_best = 1'b1;
            cmd.acc_clr  = 1'b1;
            i_nxt        = '0;
            j_nxt        = '0;
            k_nxt        = '0;
            state_nxt    = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd.rd_en = (int'(k_r) < MAT_DIM);
        k_nxt     = k_r + K_W'(1);
        if (int'(k_r) == MAT_DIM + 1) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        it_nxt = '0;
        if (i_r == j_r) begin
          cmd.root_ld_diag = 1'b1;
          state_nxt        = ST_ROOT;
        end else begin
          cmd.abs_en = 1'b1;
          state_nxt  = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.sq_en = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.root_ld_off = 1'b1;
        state_nxt       = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        it_nxt        = it_r + ITER_W'(1);
        if (int'(it_r) == ROOT_ITERS - 1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin_en = 1'b1;
        k_nxt      = '0;
        if (j_r == LAST_IDX) begin
          if (i_r == LAST_IDX) begin
            state_nxt = ST_OUT;
          end else begin
            i_nxt       = i_r + IDX_W'(1);
            j_nxt       = i_r + IDX_W'(1);
            cmd.acc_clr = 1'b1;
            state_nxt   = ST_ACC;
          end
        end else begin
          j_nxt       = j_r + IDX_W'(1);
          cmd.acc_clr = 1'b1;
          state_nxt   = ST_ACC;
        end
      end
      ST_OUT: begin
        cmd.out_en = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      it_r    <= it_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |=> state_r == ST_IDLE)
    else $error("result step not followed by idle");
  a_last_pair_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && i_r == LAST_IDX && j_r == LAST_IDX) |=> state_r == ST_OUT)
    else $error("last pair did not close the matrix");
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");
`endif

endmodule

FILE: hw/rtl/cmuc_dpath.sv
// ----------------------------------------------------------------------------
// cmuc_dpath
// Element store, complex MAC, magnitude squaring, bitwise root, max tracking.
// ----------------------------------------------------------------------------
module cmuc_dpath import cmuc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic signed [15:0]  in_elem_real,
  input  logic signed [15:0]  in_elem_imag,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_tolerance,
  output logic                out_valid,
  output logic [15:0]         out_peak_dev,
  output logic                out_exceeds
);

  logic [31:0]              mem [DEPTH];
  logic [31:0]              rda_r, rdb_r;
  logic                     v1_r, v2_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [31:0]       p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [ACC_W-1:0]  sr_r, si_r;
  logic [29:0]              ar_r, ai_r;
  logic                     sat_r;
  logic [59:0]              sqr_r, sqi_r;
  logic [ROOT_W-1:0]        v_r, r_r, bit_r;
  logic [15:0]              best_r, tol_r, out_dev_r;
  logic                     out_valid_r, out_exc_r;

  logic signed [ACC_W-1:0]  sr_abs, si_abs;
  logic [ROOT_W-1:0]        t_sum, r_fin, dev, q;
  logic [15:0]              d_val;

  assign out_valid    = out_valid_r;
  assign out_peak_dev = out_dev_r;
  assign out_exceeds  = out_exc_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && int'(cnt_r) < DEPTH) begin
      mem[cnt_r[ADDR_W-1:0]] <= {in_elem_imag, in_elem_real};
    end
    if (cmd.rd_en) begin
      rda_r <= mem[cmd.rd_a];
      rdb_r <= mem[cmd.rd_b];
    end
  end

  assign sr_abs = sr_r[ACC_W-1] ? -sr_r : sr_r;
  assign si_abs = si_r[ACC_W-1] ? -si_r : si_r;
  assign t_sum  = r_r + bit_r;
  assign r_fin  = r_r + ((v_r > r_r) ? ROOT_W'(1) : ROOT_W'(0));
  assign dev    = (r_fin >= ROOT_W'(ONE_Q14)) ? r_fin - ROOT_W'(ONE_Q14)
                                              : ROOT_W'(ONE_Q14) - r_fin;
  assign q      = (r_fin + ROOT_W'(HALF_Q14)) >> 14;

  always_comb begin
    if (cmd.diag) begin
      d_val = (dev > ROOT_W'(SAT16)) ? 16'(SAT16) : dev[15:0];
    end else if (sat_r || q > ROOT_W'(SAT16)) begin
      d_val = 16'(SAT16);
    end else begin
      d_val = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    p_rr_r <= signed'(rda_r[15:0])  * signed'(rdb_r[15:0]);
    p_ii_r <= signed'(rda_r[31:16]) * signed'(rdb_r[31:16]);
    p_ir_r <= signed'(rda_r[31:16]) * signed'(rdb_r[15:0]);
    p_ri_r <= signed'(rda_r[15:0])  * signed'(rdb_r[31:16]);
    if (cmd.acc_clr) begin
      sr_r <= '0;
      si_r <= '0;
    end else if (v2_r) begin
      sr_r <= sr_r + ACC_W'(p_rr_r) + ACC_W'(p_ii_r);
      si_r <= si_r + ACC_W'(p_ir_r) - ACC_W'(p_ri_r);
    end
    if (cmd.abs_en) begin
      sat_r <= (sr_abs >= ACC_W'(1 << 30)) || (si_abs >= ACC_W'(1 << 30));
      ar_r  <= sr_abs[29:0];
      ai_r  <= si_abs[29:0];
    end
    if (cmd.sq_en) begin
      sqr_r <= ar_r * ar_r;
      sqi_r <= ai_r * ai_r;
    end
    if (cmd.root_ld_diag || cmd.root_ld_off) begin
      v_r   <= cmd.root_ld_diag ? ROOT_W'(unsigned'(sr_r))
                                : ROOT_W'(sqr_r) + ROOT_W'(sqi_r);
      r_r   <= '0;
      bit_r <= ROOT_W'(1) << 62;
    end else if (cmd.root_step) begin
      if (v_r >= t_sum) begin
        v_r <= v_r - t_sum;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.out_en) begin
      out_dev_r <= best_r;
      out_exc_r <= best_r > tol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      cnt_r       <= '0;
      best_r      <= '0;
      tol_r       <= 16'(TOL_RESET);
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.rd_en;
      v2_r        <= v1_r;
      out_valid_r <= cmd.out_en;
      if (cfg_valid) begin
        tol_r <= cfg_tolerance;
      end
      if (cmd.wr_en) begin
        if (cmd.wr_last) begin
          cnt_r <= '0;
        end else if (int'(cnt_r) < DEPTH) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.clr_best) begin
        best_r <= '0;
      end else if (cmd.fin_en && d_val > best_r) begin
        best_r <= d_val;
      end
    end
  end

`ifndef SYNTHESIS
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.out_en))
    else $error("result strobe without result step");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= DEPTH)
    else $error("element count past store depth");
  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_en |-> bit_r == '0)
    else $error("root used before all passes ran");
`endif

endmodule
